// ===== hw/rtl/vbsp_pkg.sv =====
// Package for the voxel brush stroke painter: volume geometry, codes and types.
// No dependencies; used by vbsp_ram and the top level under hw/rtl.
`default_nettype none
package vbsp_pkg;
    localparam int SIZE_X     = 64;
    localparam int SIZE_Y     = 64;
    localparam int SIZE_Z     = 64;
    localparam int MAX_RADIUS = 30;
    localparam int XW = $clog2(SIZE_X);
    localparam int YW = $clog2(SIZE_Y);
    localparam int ZW = $clog2(SIZE_Z);
    localparam int AW = XW + YW + ZW;
    localparam int DEPTH = SIZE_X * SIZE_Y * SIZE_Z;
    localparam int CW = 6;       // coordinate field width
    localparam int LW = 16;      // label width
    localparam int RW = 5;       // radius register width
    // Signed working width for sample and disk coordinates.
    localparam int SW = 12;

    localparam logic [0:0] CMD_PAINT = 1'b0;
    localparam logic [0:0] CMD_READ  = 1'b1;

    localparam logic [0:0] REG_RADIUS = 1'b0;
    localparam logic [0:0] REG_PLANE  = 1'b1;

    localparam logic [1:0] PLANE_XZ = 2'd1;
    localparam logic [1:0] PLANE_YZ = 2'd2;

    localparam logic [23:0] STEP_NUM = 24'd15099392; // 58982 * 256
    localparam logic [16:0] T_ONE    = 17'h10000;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SQRT,
        ST_DIV,
        ST_SAMPLE,
        ST_ROUND,
        ST_DISK,
        ST_READ,
        ST_READ_WAIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic          we;
        logic [AW-1:0] waddr;
        logic [LW-1:0] wdata;
        logic [AW-1:0] raddr;
    } mem_req_t;
endpackage
`default_nettype wire

// ===== hw/rtl/vbsp_ram.sv =====
// Single-port-write, single-port-read label memory with a registered read.
// Depends on vbsp_pkg for address and data widths.
`default_nettype none
module vbsp_ram (
    input  wire logic                       clk,
    input  wire vbsp_pkg::mem_req_t         req,
    output logic [vbsp_pkg::LW-1:0]         rdata
);
    logic [vbsp_pkg::LW-1:0] mem [vbsp_pkg::DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata <= mem[req.raddr];
    end
endmodule
`default_nettype wire

// ===== hw/rtl/vbsp_isqrt.sv =====
// Bit-serial integer square root, one root bit per cycle.
// Stands alone with no package dependency; 32-bit operand, 16-bit root.
`default_nettype none
module vbsp_isqrt (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] value,
    output logic             done,
    output logic [15:0]      root
);
    logic [31:0] rem_reg, rem_next;
    logic [31:0] res_reg, res_next;
    logic [31:0] bit_reg, bit_next;
    logic        busy_reg, busy_next;

    always_comb
    begin
        rem_next  = rem_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next  = value;
            res_next  = '0;
            bit_next  = 32'h4000_0000;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_reg >= res_reg + bit_reg)
            begin
                rem_next = rem_reg - (res_reg + bit_reg);
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg[0])
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign done = busy_reg && bit_reg[0];
    assign root = res_next[15:0];
endmodule
`default_nettype wire

// ===== hw/rtl/vbsp_div.sv =====
// Restoring divider, one quotient bit per cycle: 24-bit dividend, 16-bit divisor.
// Depends on nothing outside itself.
`default_nettype none
module vbsp_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [23:0] dividend,
    input  wire logic [15:0] divisor,
    output logic             done,
    output logic [23:0]      quotient
);
    logic [23:0] q_reg, q_next;
    logic [16:0] r_reg, r_next;
    logic [15:0] d_reg;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [16:0] trial;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {r_reg[15:0], q_reg[23]};
        if (start)
        begin
            q_next    = dividend;
            r_next    = '0;
            cnt_next  = 5'd23;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (r_reg[16] || trial >= {1'b0, d_reg})
            begin
                r_next = trial - {1'b0, d_reg};
                q_next = {q_reg[22:0], 1'b1};
            end
            else
            begin
                r_next = trial;
                q_next = {q_reg[22:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd0)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        r_reg   <= r_next;
        cnt_reg <= cnt_next;
        if (start)
        begin
            d_reg <= divisor;
        end
    end

    assign done     = busy_reg && (cnt_reg == 5'd0);
    assign quotient = q_next;
endmodule
`default_nettype wire

// ===== hw/rtl/voxel_brush_stroke_painter.sv =====
// Top level of the voxel brush stroke painter: sequencer, stroke arithmetic, disk walk.
// Depends on vbsp_pkg, vbsp_ram, vbsp_isqrt and vbsp_div.
//
// Usage: a command beat enters on in_valid/in_stall; each command returns exactly
// one result beat on out_valid/out_stall. A paint walks the segment: a bit-serial
// square root and a divider set the sample step, then every sample passes the ST_SAMPLE
// and ST_ROUND states and visits all (2r+1)^2 disk offsets in turn, since the single
// write port of the label memory takes one voxel per cycle. The full diagonal has
// 122 samples. A read goes through the ST_READ and ST_READ_WAIT states, as the
// memory's read port is registered. One command is worked on at a time; in_stall
// is high while busy. After reset the block sweeps the memory to zero, one entry
// per cycle, with in_stall high; configuration writes are taken throughout.
// A result waits in the output register while out_stall is high; the next command
// is then accepted but its work waits until the result is taken.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high. Radius resets to 1, plane to the x,y plane.
`default_nettype none
module voxel_brush_stroke_painter (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [0:0]  command,
    input  wire logic [5:0]  start_x,
    input  wire logic [5:0]  start_y,
    input  wire logic [5:0]  start_z,
    input  wire logic [5:0]  end_x,
    input  wire logic [5:0]  end_y,
    input  wire logic [5:0]  end_z,
    input  wire logic [15:0] label,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             is_read,
    output logic [15:0]      read_value,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [4:0]  cfg_data
);
    localparam int SW = vbsp_pkg::SW;

    vbsp_pkg::state_t state_reg, state_next;

    logic [vbsp_pkg::RW-1:0] radius_reg;
    logic [1:0]              plane_reg;

    // Command capture.
    logic                    cmd_reg;
    logic [5:0]              sx_reg, sy_reg, sz_reg;
    logic signed [6:0]       dx_reg, dy_reg, dz_reg;
    logic [15:0]             lab_reg;

    logic [vbsp_pkg::AW-1:0] clr_reg, clr_next;
    logic [16:0]             step_reg;
    logic [17:0]             t_reg, t_next;
    logic [5:0]              rad_reg;
    logic signed [SW-1:0]    px_reg, py_reg, pz_reg;
    logic signed [SW-1:0]    a_reg, a_next, b_reg, b_next;
    logic                    ovalid_reg, ovalid_next;
    logic                    oread_reg, oread_next;
    logic [15:0]             oval_reg, oval_next;
    logic                    valid_cmd_reg, valid_cmd_next;

    // Q16 products of delta and t.
    logic signed [25:0]      mx_reg, my_reg, mz_reg;

    vbsp_pkg::mem_req_t      req;
    logic [15:0]             rdata;

    logic                    sq_start, sq_done, dv_start, dv_done;
    logic [15:0]             sq_root;
    logic [23:0]             dv_q;
    logic [31:0]             d2_shift;
    logic [15:0]             len;
    logic [14:0]             d2;

    logic signed [SW-1:0]    vx, vy, vz;
    logic                    inside_vox, in_disk;
    logic signed [SW-1:0]    r_s;
    logic                    read_in;
    logic                    acc_in;

    vbsp_ram u_ram (
        .clk   (clk),
        .req   (req),
        .rdata (rdata)
    );

    vbsp_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .value (d2_shift),
        .done  (sq_done),
        .root  (sq_root)
    );

    vbsp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (dv_start),
        .dividend (vbsp_pkg::STEP_NUM + {9'd0, len[15:1]}),
        .divisor  (len),
        .done     (dv_done),
        .quotient (dv_q)
    );

    assign d2 = 15'(dx_reg * dx_reg) + 15'(dy_reg * dy_reg) + 15'(dz_reg * dz_reg);
    assign d2_shift = {1'b0, d2, 16'd0};
    logic [15:0] root_reg;
    assign len = (root_reg < 16'd256) ? 16'd256 : root_reg;

    function automatic logic signed [SW-1:0] rnd(input logic [5:0] s,
                                                 input logic signed [25:0] m);
        logic signed [27:0] v;
        logic [27:0]        mag;
        begin
            v = $signed({2'b00, s, 16'd0}) + 28'(m);
            if (v >= 0)
            begin
                mag = 28'(v) + 28'd32768;
                rnd = SW'($signed({1'b0, mag[27:16]}));
            end
            else
            begin
                mag = 28'(-v) + 28'd32768;
                rnd = -SW'($signed({1'b0, mag[27:16]}));
            end
        end
    endfunction

    assign r_s = SW'($signed({1'b0, rad_reg}));
    assign in_disk = (a_reg * a_reg + b_reg * b_reg) < (r_s * r_s);

    always_comb
    begin
        vx = px_reg;
        vy = py_reg;
        vz = pz_reg;
        unique case (plane_reg)
            vbsp_pkg::PLANE_XZ:
            begin
                vx = px_reg + a_reg;
                vz = pz_reg + b_reg;
            end
            vbsp_pkg::PLANE_YZ:
            begin
                vy = py_reg + a_reg;
                vz = pz_reg + b_reg;
            end
            default:
            begin
                vx = px_reg + a_reg;
                vy = py_reg + b_reg;
            end
        endcase
    end

    assign inside_vox = vx >= 0 && vy >= 0 && vz >= 0 &&
                        vx < SW'(vbsp_pkg::SIZE_X) && vy < SW'(vbsp_pkg::SIZE_Y) &&
                        vz < SW'(vbsp_pkg::SIZE_Z);

    assign read_in = {26'd0, sx_reg} < 32'(vbsp_pkg::SIZE_X) &&
                     {26'd0, sy_reg} < 32'(vbsp_pkg::SIZE_Y) &&
                     {26'd0, sz_reg} < 32'(vbsp_pkg::SIZE_Z);

    assign cfg_ready = 1'b1;
    assign in_stall  = valid_cmd_reg || state_reg == vbsp_pkg::ST_CLEAR;
    assign acc_in    = in_valid && !in_stall;
    assign out_valid = ovalid_reg;
    assign is_read   = oread_reg;
    assign read_value = oval_reg;

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        t_next         = t_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        ovalid_next    = ovalid_reg && out_stall;
        oread_next     = oread_reg;
        oval_next      = oval_reg;
        valid_cmd_next = valid_cmd_reg || acc_in;
        sq_start       = 1'b0;
        req.we         = 1'b0;
        req.waddr      = clr_reg;
        req.wdata      = '0;
        req.raddr      = {sz_reg[vbsp_pkg::ZW-1:0], sy_reg[vbsp_pkg::YW-1:0],
                          sx_reg[vbsp_pkg::XW-1:0]};
        unique case (state_reg)
            vbsp_pkg::ST_CLEAR:
            begin
                req.we   = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == '1)
                begin
                    state_next = vbsp_pkg::ST_IDLE;
                end
            end
            vbsp_pkg::ST_IDLE:
            begin
                if (valid_cmd_reg && !ovalid_next)
                begin
                    if (cmd_reg == vbsp_pkg::CMD_READ)
                    begin
                        state_next = vbsp_pkg::ST_READ;
                    end
                    else
                    begin
                        sq_start   = 1'b1;
                        state_next = vbsp_pkg::ST_SQRT;
                    end
                end
            end
            vbsp_pkg::ST_SQRT:
            begin
                if (sq_done)
                begin
                    state_next = vbsp_pkg::ST_DIV;
                end
            end
            vbsp_pkg::ST_DIV:
            begin
                // The divider is started the cycle after the root registers.
                if (dv_done)
                begin
                    t_next     = '0;
                    state_next = vbsp_pkg::ST_SAMPLE;
                end
            end
            vbsp_pkg::ST_SAMPLE:
            begin
                if (t_reg > {1'b0, vbsp_pkg::T_ONE})
                begin
                    state_next = vbsp_pkg::ST_DONE;
                end
                else
                begin
                    state_next = vbsp_pkg::ST_ROUND;
                end
            end
            vbsp_pkg::ST_ROUND:
            begin
                a_next     = -r_s;
                b_next     = -r_s;
                state_next = vbsp_pkg::ST_DISK;
            end
            vbsp_pkg::ST_DISK:
            begin
                req.we    = in_disk && inside_vox;
                req.waddr = {vz[vbsp_pkg::ZW-1:0], vy[vbsp_pkg::YW-1:0],
                             vx[vbsp_pkg::XW-1:0]};
                req.wdata = lab_reg;
                if (a_reg >= r_s)
                begin
                    a_next = -r_s;
                    if (b_reg >= r_s)
                    begin
                        t_next     = t_reg + {1'b0, step_reg};
                        state_next = vbsp_pkg::ST_SAMPLE;
                    end
                    else
                    begin
                        b_next = b_reg + 1'b1;
                    end
                end
                else
                begin
                    a_next = a_reg + 1'b1;
                end
            end
            vbsp_pkg::ST_READ:
            begin
                state_next = vbsp_pkg::ST_READ_WAIT;
            end
            vbsp_pkg::ST_READ_WAIT:
            begin
                ovalid_next    = 1'b1;
                oread_next     = 1'b1;
                oval_next      = read_in ? rdata : 16'd0;
                valid_cmd_next = acc_in;
                state_next     = vbsp_pkg::ST_IDLE;
            end
            vbsp_pkg::ST_DONE:
            begin
                ovalid_next    = 1'b1;
                oread_next     = 1'b0;
                oval_next      = 16'd0;
                valid_cmd_next = acc_in;
                state_next     = vbsp_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = vbsp_pkg::ST_IDLE;
            end
        endcase
    end

    logic div_go_reg;
    assign dv_start = div_go_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= vbsp_pkg::ST_CLEAR;
            clr_reg       <= '0;
            radius_reg    <= 5'd1;
            plane_reg     <= 2'd0;
            ovalid_reg    <= 1'b0;
            valid_cmd_reg <= 1'b0;
            div_go_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            ovalid_reg    <= ovalid_next;
            valid_cmd_reg <= valid_cmd_next;
            div_go_reg    <= sq_done;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == vbsp_pkg::REG_RADIUS)
                begin
                    radius_reg <= cfg_data;
                end
                else
                begin
                    plane_reg <= cfg_data[1:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg     <= t_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        oread_reg <= oread_next;
        oval_reg  <= oval_next;
        if (acc_in)
        begin
            cmd_reg <= command;
            sx_reg  <= start_x;
            sy_reg  <= start_y;
            sz_reg  <= start_z;
            dx_reg  <= $signed({1'b0, end_x}) - $signed({1'b0, start_x});
            dy_reg  <= $signed({1'b0, end_y}) - $signed({1'b0, start_y});
            dz_reg  <= $signed({1'b0, end_z}) - $signed({1'b0, start_z});
            lab_reg <= label;
            rad_reg <= (radius_reg > 5'(vbsp_pkg::MAX_RADIUS)) ?
                       6'(vbsp_pkg::MAX_RADIUS) : {1'b0, radius_reg};
        end
        if (sq_done)
        begin
            root_reg <= sq_root;
        end
        if (dv_done)
        begin
            step_reg <= (dv_q == 24'd0) ? 17'd1 : dv_q[16:0];
        end
        if (state_reg == vbsp_pkg::ST_SAMPLE)
        begin
            mx_reg <= 26'(dx_reg * $signed({1'b0, t_reg}));
            my_reg <= 26'(dy_reg * $signed({1'b0, t_reg}));
            mz_reg <= 26'(dz_reg * $signed({1'b0, t_reg}));
        end
        if (state_reg == vbsp_pkg::ST_ROUND)
        begin
            px_reg <= rnd(sx_reg, mx_reg);
            py_reg <= rnd(sy_reg, my_reg);
            pz_reg <= rnd(sz_reg, mz_reg);
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == vbsp_pkg::ST_CLEAR |-> in_stall)
        else $error("command taken during clear sweep");
    assert property (@(posedge clk) disable iff (!rst_n)
        req.we && state_reg == vbsp_pkg::ST_DISK |-> in_disk && inside_vox)
        else $error("write outside disk");
    assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg && out_stall |=> ovalid_reg && $stable(oval_reg))
        else $error("stalled result changed");
endmodule
`default_nettype wire

// ===== test/tb_voxel_brush_stroke_painter.sv =====
// Self-checking testbench for voxel_brush_stroke_painter: paints and reads are
// checked against a label volume mirrored inside the bench. Depends on vbsp_pkg
// and on the RTL under hw/rtl.
module tb_voxel_brush_stroke_painter;
    timeunit 1ns;
    timeprecision 1ps;
    import vbsp_pkg::*;

    typedef struct {
        logic [0:0]  cmd;
        logic [5:0]  sx, sy, sz, ex, ey, ez;
        logic [15:0] lab;
    } brush_cmd_t;

    typedef struct {
        logic        rd;
        logic [15:0] value;
    } brush_res_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [0:0]  command = CMD_PAINT;
    logic [5:0]  start_x = '0, start_y = '0, start_z = '0;
    logic [5:0]  end_x = '0, end_y = '0, end_z = '0;
    logic [15:0] label = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        is_read;
    logic [15:0] read_value;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [0:0]  cfg_index = REG_RADIUS;
    logic [4:0]  cfg_data = '0;

    voxel_brush_stroke_painter i_dut (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Mirror of the block: label volume and its two registers.
    logic [15:0] vol_mirror [DEPTH];
    logic [4:0]  radius_reg = 5'd1;
    logic [1:0]  plane_reg = 2'd0;

    brush_cmd_t  cmd_q [$];
    brush_res_t  result_q [$];
    int          error_count = 0;
    int          tx_gap = 0;
    int          rx_wait = 0;
    int          hold_cnt = 0;
    int          hold_seq = 0;
    int          hold_seen = 0;
    int          quiet_cycles = 0;
    bit          burst = 1'b0;
    logic [5:0]  last_x = '0, last_y = '0, last_z = '0;

    function automatic longint unsigned root_of(longint unsigned v);
        longint unsigned res = 0;
        longint unsigned bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint round_half_away(longint v);
        if (v >= 0)
            return (v + 32768) / 65536;
        return -((-v + 32768) / 65536);
    endfunction

    function automatic void stamp_disk(longint px, longint py, longint pz, longint r,
                                       logic [15:0] lab);
        longint x, y, z;
        for (longint b = -r; b <= r; b++)
            for (longint a = -r; a <= r; a++)
            begin
                if (a * a + b * b >= r * r)
                    continue;
                x = px; y = py; z = pz;
                if (plane_reg == PLANE_XZ)
                begin
                    x += a; z += b;
                end
                else if (plane_reg == PLANE_YZ)
                begin
                    y += a; z += b;
                end
                else
                begin
                    x += a; y += b;
                end
                if (x < 0 || y < 0 || z < 0 || x >= SIZE_X || y >= SIZE_Y || z >= SIZE_Z)
                    continue;
                vol_mirror[x + SIZE_X * (y + SIZE_Y * z)] = lab;
            end
    endfunction

    // Applies one command to the mirror and returns the result it must produce.
    function automatic brush_res_t apply_command(brush_cmd_t c);
        brush_res_t res;
        longint s[3], d[3];
        longint unsigned d2, len;
        longint stp, r;
        res.rd = 1'b0;
        res.value = '0;
        if (c.cmd == CMD_READ)
        begin
            res.rd = 1'b1;
            res.value = vol_mirror[c.sx + SIZE_X * (c.sy + SIZE_Y * c.sz)];
            return res;
        end
        s[0] = c.sx; s[1] = c.sy; s[2] = c.sz;
        d[0] = longint'(c.ex) - s[0];
        d[1] = longint'(c.ey) - s[1];
        d[2] = longint'(c.ez) - s[2];
        d2 = d[0] * d[0] + d[1] * d[1] + d[2] * d[2];
        len = root_of(d2 << 16);
        if (len < 256)
            len = 256;
        stp = (15099392 + len / 2) / len;
        if (stp < 1)
            stp = 1;
        r = (radius_reg > MAX_RADIUS) ? MAX_RADIUS : radius_reg;
        for (longint t = 0; t <= 65536; t += stp)
            stamp_disk(round_half_away(s[0] * 65536 + d[0] * t),
                       round_half_away(s[1] * 65536 + d[1] * t),
                       round_half_away(s[2] * 65536 + d[2] * t), r, c.lab);
        return res;
    endfunction

    task automatic report(string what, logic [15:0] got, logic [15:0] want);
        $display("mismatch on %s: got %0h, expected %0h at %0t", what, got, want, $time);
        error_count++;
    endtask

    // Sender: one beat per item, a random gap after each unless in burst mode.
    always @(posedge clk or negedge rst_n)
    begin
        brush_cmd_t c;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            tx_gap <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                c.cmd = command; c.lab = label;
                c.sx = start_x; c.sy = start_y; c.sz = start_z;
                c.ex = end_x; c.ey = end_y; c.ez = end_z;
                result_q = {result_q, apply_command(c)};
            end
            if (!in_valid || !in_stall)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap <= tx_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (cmd_q.size() > 0)
                begin
                    c = cmd_q.pop_front();
                    command <= c.cmd; label <= c.lab;
                    start_x <= c.sx; start_y <= c.sy; start_z <= c.sz;
                    end_x <= c.ex; end_y <= c.ey; end_z <= c.ez;
                    in_valid <= 1'b1;
                    tx_gap <= burst ? 0 : $urandom_range(0, 4);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stall per beat, plus long hold-offs on request.
    always @(posedge clk)
    begin
        if (hold_seq != hold_seen)
        begin
            hold_seen <= hold_seq;
            hold_cnt <= 300;
            out_stall <= 1'b1;
        end
        else if (hold_cnt > 0)
        begin
            hold_cnt <= hold_cnt - 1;
            out_stall <= 1'b1;
        end
        else if (out_valid && !out_stall)
        begin
            rx_wait <= burst ? 0 : $urandom_range(0, 4);
            out_stall <= 1'b0;
        end
        else if (rx_wait > 0)
        begin
            rx_wait <= rx_wait - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        brush_res_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (result_q.size() == 0)
                report("unexpected result beat", read_value, 16'd0);
            else
            begin
                w = result_q.pop_front();
                if (is_read !== w.rd)
                    report("is_read", 16'(is_read), 16'(w.rd));
                if (read_value !== w.value)
                    report("read_value", read_value, w.value);
            end
        end
    end

    // A clear pass after reset and the largest paint both fit well within this.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= 2000000)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic write_reg(logic [0:0] idx, logic [4:0] data);
        @(posedge clk);
        cfg_index <= idx;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_RADIUS)
            radius_reg = data;
        else
            plane_reg = data[1:0];
    endtask

    // Sampled away from the rising edge so the sender's updates have settled.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (cmd_q.size() > 0 || in_valid || result_q.size() > 0);
        repeat (20) @(posedge clk);
    endtask

    function automatic logic [5:0] near(logic [5:0] v, int spread);
        int n;
        n = int'(v) + $urandom_range(0, 2 * spread) - spread;
        return (n < 0) ? 6'd0 : (n > 63) ? 6'd63 : 6'(n);
    endfunction

    task automatic add_cmd(logic [0:0] cmd, logic [5:0] sx, sy, sz, ex, ey, ez,
                           logic [15:0] lab);
        brush_cmd_t c;
        c.cmd = cmd; c.lab = lab;
        c.sx = sx; c.sy = sy; c.sz = sz;
        c.ex = ex; c.ey = ey; c.ez = ez;
        cmd_q = {cmd_q, c};
    endtask

    // Short strokes mixed with reads, mostly around the last stroke's start; some long strokes unless flat.
    task automatic random_strokes(int count, int spread, bit flat);
        logic [5:0] sx, sy, sz;
        int sp;
        repeat (count)
        begin
            if ($urandom_range(0, 9) < 5)
            begin
                sx = 6'($urandom_range(0, 63)); sy = 6'($urandom_range(0, 63));
                sz = 6'($urandom_range(0, 63));
                sp = (!flat && $urandom_range(0, 9) == 0) ? 63 : spread;
                add_cmd(CMD_PAINT, sx, sy, sz, near(sx, sp), near(sy, sp), near(sz, sp),
                        16'($urandom));
                last_x = sx; last_y = sy; last_z = sz;
            end
            else if ($urandom_range(0, 9) < 8)
                add_cmd(CMD_READ, near(last_x, 4), near(last_y, 4), near(last_z, 4),
                        6'($urandom), 6'($urandom), 6'($urandom), 16'($urandom));
            else
                add_cmd(CMD_READ, 6'($urandom), 6'($urandom), 6'($urandom),
                        6'($urandom), 6'($urandom), 6'($urandom), 16'($urandom));
        end
    endtask

    initial
    begin
        for (int i = 0; i < DEPTH; i++)
            vol_mirror[i] = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: corners, full diagonal, zero length, eraser, reads.
        add_cmd(CMD_READ, 6'd63, 6'd63, 6'd63, 6'd0, 6'd0, 6'd0, 16'hFFFF);
        add_cmd(CMD_PAINT, 6'd0, 6'd0, 6'd0, 6'd63, 6'd63, 6'd63, 16'hFFFF);
        add_cmd(CMD_READ, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 16'h0);
        add_cmd(CMD_READ, 6'd63, 6'd63, 6'd63, 6'd63, 6'd63, 6'd63, 16'h0);
        add_cmd(CMD_READ, 6'd31, 6'd32, 6'd32, 6'd0, 6'd0, 6'd0, 16'h0);
        add_cmd(CMD_PAINT, 6'd63, 6'd0, 6'd63, 6'd63, 6'd0, 6'd63, 16'hA5A5);
        add_cmd(CMD_READ, 6'd63, 6'd0, 6'd63, 6'd0, 6'd0, 6'd0, 16'h0);
        add_cmd(CMD_PAINT, 6'd10, 6'd10, 6'd10, 6'd20, 6'd10, 6'd10, 16'h5A5A);
        add_cmd(CMD_READ, 6'd15, 6'd10, 6'd10, 6'd0, 6'd0, 6'd0, 16'h0);
        add_cmd(CMD_PAINT, 6'd14, 6'd10, 6'd10, 6'd16, 6'd10, 6'd10, 16'h0);
        add_cmd(CMD_READ, 6'd15, 6'd10, 6'd10, 6'd0, 6'd0, 6'd0, 16'h0);
        add_cmd(CMD_READ, 6'd17, 6'd10, 6'd10, 6'd0, 6'd0, 6'd0, 16'h0);
        wait_drained();

        // Large radius over an edge, saturated radius, then an empty disk.
        write_reg(REG_RADIUS, 5'd30);
        write_reg(REG_PLANE, 5'd1);
        add_cmd(CMD_PAINT, 6'd2, 6'd40, 6'd60, 6'd2, 6'd40, 6'd60, 16'h1234);
        add_cmd(CMD_READ, 6'd30, 6'd40, 6'd40, 6'd0, 6'd0, 6'd0, 16'h0);
        add_cmd(CMD_READ, 6'd31, 6'd40, 6'd60, 6'd0, 6'd0, 6'd0, 16'h0);
        wait_drained();
        write_reg(REG_RADIUS, 5'd31);
        write_reg(REG_PLANE, 5'b11110);
        add_cmd(CMD_PAINT, 6'd40, 6'd40, 6'd5, 6'd40, 6'd41, 6'd5, 16'h4321);
        add_cmd(CMD_READ, 6'd40, 6'd29, 6'd34, 6'd0, 6'd0, 6'd0, 16'h0);
        add_cmd(CMD_READ, 6'd40, 6'd11, 6'd5, 6'd0, 6'd0, 6'd0, 16'h0);
        wait_drained();
        write_reg(REG_RADIUS, 5'd0);
        add_cmd(CMD_PAINT, 6'd40, 6'd40, 6'd5, 6'd45, 6'd40, 6'd5, 16'h7777);
        add_cmd(CMD_READ, 6'd40, 6'd40, 6'd5, 6'd0, 6'd0, 6'd0, 16'h0);
        wait_drained();

        // Random phases over several settings, plane code 3 among them.
        write_reg(REG_RADIUS, 5'd1);
        write_reg(REG_PLANE, 5'd3);
        random_strokes(22, 6, 1'b0);
        wait_drained();
        write_reg(REG_RADIUS, 5'd3);
        write_reg(REG_PLANE, 5'd0);
        burst = 1'b1;
        random_strokes(22, 5, 1'b0);
        wait_drained();
        burst = 1'b0;
        write_reg(REG_RADIUS, 5'd2);
        write_reg(REG_PLANE, 5'd2);
        random_strokes(22, 8, 1'b0);
        wait_drained();

        // Receiver holds off while commands keep coming, so the input backs up.
        hold_seq <= hold_seq + 1;
        burst = 1'b1;
        random_strokes(10, 2, 1'b1);
        wait_drained();
        burst = 1'b0;
        write_reg(REG_RADIUS, 5'd5);
        write_reg(REG_PLANE, 5'd1);
        random_strokes(22, 4, 1'b1);
        wait_drained();
        write_reg(REG_RADIUS, 5'd1);
        write_reg(REG_PLANE, 5'd0);
        random_strokes(22, 10, 1'b0);
        wait_drained();

        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
